>>> hdl/bounded_char_sequence_store_assert.svh
// Assertion macros used by the sequence store RTL.
`ifndef BOUNDED_CHAR_SEQUENCE_STORE_ASSERT_SVH
`define BOUNDED_CHAR_SEQUENCE_STORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, held off during reset.
`define BCSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcss assertion failed");
// Next-cycle implication, held off during reset.
`define BCSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcss assertion failed");
`else
`define BCSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BCSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/bcss_pkg.sv
// Types, codes and control store of the character sequence store.
package bcss_pkg;

	localparam int FUNC_W   = 4;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int STEP_W   = 5;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [STEP_W-1:0]   step_t;
	typedef logic [2:0]          ptr_op_t;
	typedef logic [2:0]          idx_op_t;
	typedef logic [1:0]          cnt_op_t;
	typedef logic [1:0]          roff_t;
	typedef logic [2:0]          cond_t;

	// command codes
	localparam func_t CMD_PUSH_FRONT    = 4'd0;
	localparam func_t CMD_PUSH_BACK     = 4'd1;
	localparam func_t CMD_INSERT_AT     = 4'd2;
	localparam func_t CMD_SORTED_INSERT = 4'd3;
	localparam func_t CMD_POP_FRONT     = 4'd4;
	localparam func_t CMD_POP_BACK      = 4'd5;
	localparam func_t CMD_REMOVE_AT     = 4'd6;
	localparam func_t CMD_REPLACE       = 4'd7;
	localparam func_t CMD_READ_AT       = 4'd8;
	localparam func_t CMD_FIRST         = 4'd9;
	localparam func_t CMD_LAST          = 4'd10;
	localparam func_t CMD_CLEAR         = 4'd11;

	// status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_FULL  = 2'd3;

	// pointer operations
	localparam ptr_op_t PTR_HOLD  = 3'd0;
	localparam ptr_op_t PTR_ZERO  = 3'd1;
	localparam ptr_op_t PTR_CNT   = 3'd2;
	localparam ptr_op_t PTR_CNTM1 = 3'd3;
	localparam ptr_op_t PTR_POS   = 3'd4;
	localparam ptr_op_t PTR_INC   = 3'd5;
	localparam ptr_op_t PTR_DEC   = 3'd6;

	// target index operations
	localparam idx_op_t IDX_HOLD = 3'd0;
	localparam idx_op_t IDX_ZERO = 3'd1;
	localparam idx_op_t IDX_CNT  = 3'd2;
	localparam idx_op_t IDX_POS  = 3'd3;
	localparam idx_op_t IDX_LESS = 3'd4;

	// length operations
	localparam cnt_op_t CNT_HOLD = 2'd0;
	localparam cnt_op_t CNT_INC  = 2'd1;
	localparam cnt_op_t CNT_DEC  = 2'd2;
	localparam cnt_op_t CNT_ZERO = 2'd3;

	// read address relative to the pointer
	localparam roff_t RD_AT    = 2'd0;
	localparam roff_t RD_BELOW = 2'd1;
	localparam roff_t RD_ABOVE = 2'd2;

	// jump conditions
	localparam cond_t COND_NEVER       = 3'd0;
	localparam cond_t COND_ALWAYS      = 3'd1;
	localparam cond_t COND_PTR_GT_IDX  = 3'd2;
	localparam cond_t COND_PTR1_LT_CNT = 3'd3;
	localparam cond_t COND_PTR_LT_CNT  = 3'd4;

	// control store addresses
	localparam step_t STEP_IDLE  = 5'd0;
	localparam step_t STEP_FIN   = 5'd1;
	localparam step_t STEP_PFRNT = 5'd2;
	localparam step_t STEP_PBACK = 5'd3;
	localparam step_t STEP_INSAT = 5'd4;
	localparam step_t STEP_SORT0 = 5'd5;
	localparam step_t STEP_SORT1 = 5'd6;
	localparam step_t STEP_SORT2 = 5'd7;
	localparam step_t STEP_UP    = 5'd8;
	localparam step_t STEP_PUT   = 5'd9;
	localparam step_t STEP_POPF  = 5'd10;
	localparam step_t STEP_POPB  = 5'd11;
	localparam step_t STEP_REMAT = 5'd12;
	localparam step_t STEP_DOWN  = 5'd13;
	localparam step_t STEP_DROP  = 5'd14;
	localparam step_t STEP_REPL0 = 5'd15;
	localparam step_t STEP_REPL1 = 5'd16;
	localparam step_t STEP_FIRST = 5'd17;
	localparam step_t STEP_LAST  = 5'd18;
	localparam step_t STEP_RDAT  = 5'd19;
	localparam step_t STEP_RD1   = 5'd20;
	localparam step_t STEP_RD2   = 5'd21;
	localparam step_t STEP_CLR   = 5'd22;

	typedef struct packed {
		ptr_op_t ptr_op;
		roff_t   roff;
		idx_op_t idx_op;
		logic    wr_ch;
		cnt_op_t cnt_op;
		logic    clr_less;
		logic    scan;
		logic    shift;
		logic    grab;
		logic    done;
		cond_t   cond;
		step_t   target;
	} uword_t;

	function automatic uword_t uw(input ptr_op_t ptr_op, input roff_t roff,
			input idx_op_t idx_op, input logic wr_ch, input cnt_op_t cnt_op,
			input logic clr_less, input logic scan, input logic shift,
			input logic grab, input logic done, input cond_t cond, input step_t target);
		uword_t w;
		w.ptr_op   = ptr_op;
		w.roff     = roff;
		w.idx_op   = idx_op;
		w.wr_ch    = wr_ch;
		w.cnt_op   = cnt_op;
		w.clr_less = clr_less;
		w.scan     = scan;
		w.shift    = shift;
		w.grab     = grab;
		w.done     = done;
		w.cond     = cond;
		w.target   = target;
		return w;
	endfunction

	// Control store: one word per step.
	function automatic uword_t ucode(input step_t step);
		uword_t w;
		unique case (step)
			STEP_FIN:   w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b1, COND_ALWAYS, STEP_IDLE);
			STEP_PFRNT: w = uw(PTR_CNT, RD_AT, IDX_ZERO, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_UP);
			STEP_PBACK: w = uw(PTR_CNT, RD_AT, IDX_CNT, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_UP);
			STEP_INSAT: w = uw(PTR_CNT, RD_AT, IDX_POS, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_UP);
			STEP_SORT0: w = uw(PTR_ZERO, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b1, 1'b0, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_IDLE);
			STEP_SORT1: w = uw(PTR_INC, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b1, 1'b0, 1'b0, 1'b0, COND_PTR_LT_CNT, STEP_SORT1);
			STEP_SORT2: w = uw(PTR_CNT, RD_AT, IDX_LESS, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_IDLE);
			STEP_UP:    w = uw(PTR_DEC, RD_BELOW, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_PTR_GT_IDX, STEP_UP);
			STEP_PUT:   w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b1, CNT_INC,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_FIN);
			STEP_POPF:  w = uw(PTR_ZERO, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_DOWN);
			STEP_POPB:  w = uw(PTR_CNTM1, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_DOWN);
			STEP_REMAT: w = uw(PTR_POS, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_IDLE);
			STEP_DOWN:  w = uw(PTR_INC, RD_ABOVE, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_PTR1_LT_CNT, STEP_DOWN);
			STEP_DROP:  w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b0, CNT_DEC,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_FIN);
			STEP_REPL0: w = uw(PTR_HOLD, RD_AT, IDX_POS, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_IDLE);
			STEP_REPL1: w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b1, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_FIN);
			STEP_FIRST: w = uw(PTR_ZERO, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_RD1);
			STEP_LAST:  w = uw(PTR_CNTM1, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_RD1);
			STEP_RDAT:  w = uw(PTR_POS, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_IDLE);
			STEP_RD1:   w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_NEVER, STEP_IDLE);
			STEP_RD2:   w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b1, 1'b0, COND_ALWAYS, STEP_FIN);
			STEP_CLR:   w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b0, CNT_ZERO,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_FIN);
			// idle and unused addresses: no operation, go to or stay in idle
			default:    w = uw(PTR_HOLD, RD_AT, IDX_HOLD, 1'b0, CNT_HOLD,
					1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS, STEP_IDLE);
		endcase
		return w;
	endfunction

	// First step of each command's routine.
	function automatic step_t entry_step(input func_t func);
		step_t s;
		unique case (func)
			CMD_PUSH_FRONT:    s = STEP_PFRNT;
			CMD_PUSH_BACK:     s = STEP_PBACK;
			CMD_INSERT_AT:     s = STEP_INSAT;
			CMD_SORTED_INSERT: s = STEP_SORT0;
			CMD_POP_FRONT:     s = STEP_POPF;
			CMD_POP_BACK:      s = STEP_POPB;
			CMD_REMOVE_AT:     s = STEP_REMAT;
			CMD_REPLACE:       s = STEP_REPL0;
			CMD_READ_AT:       s = STEP_RDAT;
			CMD_FIRST:         s = STEP_FIRST;
			CMD_LAST:          s = STEP_LAST;
			CMD_CLEAR:         s = STEP_CLR;
			default:           s = STEP_FIN;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/bcss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bcss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/bounded_char_sequence_store.sv
// Bounded character sequence store: top level with microcoded sequencer and datapath.
// One command at a time. Inserts and removes move one entry per cycle through the RAM,
// and a sorted insert first scans the stored entries to find its index. A new command
// can be taken as soon as the result is registered. Reset empties the store; RAM is
// not cleared.
`include "bounded_char_sequence_store_assert.svh"

module bounded_char_sequence_store #(
	parameter int CAPACITY = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bcss_pkg::FUNC_W-1:0]    func,
	input  logic [bcss_pkg::CHAR_W-1:0]    char_in,
	input  logic [bcss_pkg::POS_W-1:0]     position,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bcss_pkg::CHAR_W-1:0]    char_out,
	output logic [$clog2(CAPACITY + 1)-1:0] count,
	output logic [bcss_pkg::STATUS_W-1:0]  status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = (CNT_W > bcss_pkg::POS_W) ? CNT_W : bcss_pkg::POS_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	bcss_pkg::step_t   upc_q;
	bcss_pkg::uword_t  uw;
	bcss_pkg::status_t chk_status;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] less_q;
	logic [bcss_pkg::CHAR_W-1:0] ch_q;
	logic [bcss_pkg::POS_W-1:0]  pos_q;
	logic [bcss_pkg::CHAR_W-1:0] rd_q;
	bcss_pkg::status_t st_q;

	logic          pend_s1;
	logic          cmp_s1;
	logic [AW-1:0] waddr_s1;

	logic out_valid_q;
	logic [bcss_pkg::CHAR_W-1:0] char_out_q;
	logic [CNT_W-1:0]            count_q;
	bcss_pkg::status_t           status_q;

	logic [CW-1:0]    pos_x;
	logic [CW-1:0]    pos_qx;
	logic [CW-1:0]    cnt_x;
	logic [CNT_W:0]   ptr_inc;
	logic [CNT_W-1:0] ptr_dec;
	logic             cond_true;
	logic             finish;
	logic             accept;

	logic [AW-1:0]               raddr;
	logic [bcss_pkg::CHAR_W-1:0] rdata;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [bcss_pkg::CHAR_W-1:0] ram_wdata;

	assign uw       = bcss_pkg::ucode(upc_q);
	assign in_ready = (upc_q == bcss_pkg::STEP_IDLE);
	assign accept   = in_valid && in_ready;
	assign finish   = uw.done && (!out_valid_q || out_ready);

	assign pos_x   = CW'(position);
	assign pos_qx  = CW'(pos_q);
	assign cnt_x   = CW'(cnt_q);
	assign ptr_inc = {1'b0, ptr_q} + 1'b1;
	assign ptr_dec = ptr_q - 1'b1;

	// Reject checks on the incoming command against the current length.
	always_comb begin
		chk_status = bcss_pkg::ST_OK;
		unique case (func) inside
			bcss_pkg::CMD_PUSH_FRONT, bcss_pkg::CMD_PUSH_BACK,
			bcss_pkg::CMD_SORTED_INSERT: begin
				if (cnt_q == CAP_C) chk_status = bcss_pkg::ST_FULL;
			end
			bcss_pkg::CMD_INSERT_AT: begin
				if (pos_x > cnt_x) chk_status = bcss_pkg::ST_RANGE;
				else if (cnt_q == CAP_C) chk_status = bcss_pkg::ST_FULL;
			end
			bcss_pkg::CMD_POP_FRONT, bcss_pkg::CMD_POP_BACK,
			bcss_pkg::CMD_FIRST, bcss_pkg::CMD_LAST: begin
				if (cnt_q == '0) chk_status = bcss_pkg::ST_EMPTY;
			end
			bcss_pkg::CMD_REMOVE_AT: begin
				if (cnt_q == '0) begin
					chk_status = (pos_x == '0) ? bcss_pkg::ST_EMPTY : bcss_pkg::ST_RANGE;
				end else if (pos_x >= cnt_x) begin
					chk_status = bcss_pkg::ST_RANGE;
				end
			end
			bcss_pkg::CMD_REPLACE, bcss_pkg::CMD_READ_AT: begin
				if (pos_x >= cnt_x) chk_status = bcss_pkg::ST_RANGE;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (uw.cond)
			bcss_pkg::COND_ALWAYS:      cond_true = 1'b1;
			bcss_pkg::COND_PTR_GT_IDX:  cond_true = (ptr_q > idx_q);
			bcss_pkg::COND_PTR1_LT_CNT: cond_true = (ptr_inc < {1'b0, cnt_q});
			bcss_pkg::COND_PTR_LT_CNT:  cond_true = (ptr_q < cnt_q);
			default:                    cond_true = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uw.roff)
			bcss_pkg::RD_BELOW: raddr = ptr_dec[AW-1:0];
			bcss_pkg::RD_ABOVE: raddr = ptr_inc[AW-1:0];
			default:            raddr = ptr_q[AW-1:0];
		endcase
	end

	// A pending move owns the write port; otherwise the command writes its character.
	assign ram_we    = pend_s1 || uw.wr_ch;
	assign ram_waddr = pend_s1 ? waddr_s1 : idx_q[AW-1:0];
	assign ram_wdata = pend_s1 ? rdata : ch_q;

	bcss_ram #(
		.WIDTH(bcss_pkg::CHAR_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= bcss_pkg::STEP_IDLE;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			cmp_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				if (in_valid) begin
					upc_q <= (chk_status != bcss_pkg::ST_OK) ? bcss_pkg::STEP_FIN
						: bcss_pkg::entry_step(func);
				end
			end else if (uw.done) begin
				if (finish) upc_q <= uw.target;
			end else begin
				upc_q <= cond_true ? uw.target : upc_q + 1'b1;
			end

			pend_s1 <= uw.shift && cond_true;
			cmp_s1  <= uw.scan && cond_true;

			unique case (uw.cnt_op)
				bcss_pkg::CNT_INC:  cnt_q <= cnt_q + 1'b1;
				bcss_pkg::CNT_DEC:  cnt_q <= cnt_q - 1'b1;
				bcss_pkg::CNT_ZERO: cnt_q <= '0;
				default:            ;
			endcase

			if (finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= char_in;
			pos_q <= position;
			st_q  <= chk_status;
		end

		if (accept) rd_q <= '0;
		else if (uw.grab) rd_q <= rdata;

		unique case (uw.ptr_op)
			bcss_pkg::PTR_ZERO:  ptr_q <= '0;
			bcss_pkg::PTR_CNT:   ptr_q <= cnt_q;
			bcss_pkg::PTR_CNTM1: ptr_q <= cnt_q - 1'b1;
			bcss_pkg::PTR_POS:   ptr_q <= pos_qx[CNT_W-1:0];
			bcss_pkg::PTR_INC:   ptr_q <= ptr_inc[CNT_W-1:0];
			bcss_pkg::PTR_DEC:   ptr_q <= ptr_dec;
			default:             ;
		endcase

		unique case (uw.idx_op)
			bcss_pkg::IDX_ZERO: idx_q <= '0;
			bcss_pkg::IDX_CNT:  idx_q <= cnt_q;
			bcss_pkg::IDX_POS:  idx_q <= pos_qx[CNT_W-1:0];
			bcss_pkg::IDX_LESS: idx_q <= less_q;
			default:            ;
		endcase

		// count entries below the new character, one per cycle
		if (uw.clr_less) less_q <= '0;
		else if (cmp_s1 && (rdata < ch_q)) less_q <= less_q + 1'b1;

		waddr_s1 <= ptr_q[AW-1:0];

		if (finish) begin
			char_out_q <= rd_q;
			count_q    <= cnt_q;
			status_q   <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_out_q;
	assign count     = count_q;
	assign status    = status_q;

	`BCSS_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP_C)
	`BCSS_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, upc_q != bcss_pkg::STEP_IDLE)
	`BCSS_ASSERT_IMPL(a_wport_single, clk, arst_n, pend_s1, !uw.wr_ch && !cmp_s1)
	`BCSS_ASSERT_NEXT(a_cnt_step, clk, arst_n, 1'b1, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) || (cnt_q == $past(cnt_q) - 1'b1) || (cnt_q == '0))
	`BCSS_ASSERT_IMPL(a_result_from_done, clk, arst_n, $rose(out_valid_q), $past(uw.done))

endmodule
